[design/paf_pkg.sv]
// Package for the I/O port access filter: codes, constants and payload types.
// No dependencies; paf_table and io_port_access_filter import it.
`default_nettype none

package paf_pkg;

  // Table size and search index width (covers first_entry + entries_in_use and depth 256)
  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned SEARCH_W        = 9;
  localparam int unsigned WORD_W          = 32;

  localparam logic [WORD_W-1:0] ALIGN_MASK     = 32'h0000_0003;
  localparam logic [WORD_W-1:0] GUARD_SPAN     = 32'h0000_0B74;
  localparam logic [WORD_W-1:0] FULL_MASK      = '1;
  localparam logic [WORD_W-1:0] GUARD_BASE_RST = 32'hF800_0000;

  // Configuration register indexes
  localparam logic [1:0] CFG_ENTRIES_IN_USE    = 2'd0;
  localparam logic [1:0] CFG_FIRST_ENTRY       = 2'd1;
  localparam logic [1:0] CFG_GUARD_WINDOW_BASE = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_MISALIGNED = 2'd1,
    ST_DENIED     = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [3:0]        entry_slot;
    logic              entry_restricted;
    logic [WORD_W-1:0] entry_address;
    logic [WORD_W-1:0] entry_extent;
    logic [WORD_W-1:0] port_address;
    logic [WORD_W-1:0] write_value;
    logic [WORD_W-1:0] device_value;
  } paf_in_t;

  typedef struct packed {
    status_e           status;
    logic              bus_write;
    logic [WORD_W-1:0] bus_address;
    logic [WORD_W-1:0] write_data;
    logic [WORD_W-1:0] read_data;
    logic              guard_unlock;
  } paf_out_t;

  // Table write request from the compare stage
  typedef struct packed {
    logic              we;
    logic [3:0]        slot;
    logic              restricted;
    logic [WORD_W-1:0] base;
    logic [WORD_W-1:0] extent;
  } paf_load_t;

endpackage : paf_pkg

`default_nettype wire

[design/paf_stream_if.sv]
// Valid/ready stream channel carrying one payload item per handshake.
// Payload type is a parameter; used with the paf_pkg payload structs.
`default_nettype none

interface paf_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface : paf_stream_if

`default_nettype wire

[design/paf_table.sv]
// Entry table of the access filter and the per-entry window/address compare.
// Depends on paf_pkg.
`default_nettype none

module paf_table #(
  parameter int unsigned TABLE_DEPTH = paf_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                                        clk_i,
  input  wire paf_pkg::paf_load_t                          load_i,
  input  wire logic [4:0]                                  count_i,
  input  wire logic [3:0]                                  first_i,
  input  wire logic [paf_pkg::WORD_W-1:0]                  addr_i,
  output logic      [TABLE_DEPTH-1:0]                      hit_o,
  output logic      [TABLE_DEPTH-1:0][paf_pkg::WORD_W-1:0] mask_o
);
  import paf_pkg::*;

  logic [TABLE_DEPTH-1:0]             kind_q;
  logic [TABLE_DEPTH-1:0][WORD_W-1:0] base_q;
  logic [TABLE_DEPTH-1:0][WORD_W-1:0] extent_q;
  logic [SEARCH_W-1:0]                win_lo;
  logic [SEARCH_W-1:0]                win_end;

  assign win_lo  = SEARCH_W'(first_i);
  assign win_end = SEARCH_W'(first_i) + SEARCH_W'(count_i);

  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_entry
    localparam logic [SEARCH_W-1:0] IDX = SEARCH_W'(j);
    logic            in_win;
    logic [WORD_W+2:0] top;

    always_ff @(posedge clk_i) begin
      if (load_i.we && (SEARCH_W'(load_i.slot) == IDX)) begin
        kind_q[j]   <= load_i.restricted;
        base_q[j]   <= load_i.base;
        extent_q[j] <= load_i.extent;
      end
    end

    // Exclusive end of the covered span, kept wide so it never wraps
    assign top = kind_q[j] ? ((WORD_W+3)'(base_q[j]) + (WORD_W+3)'(4))
                           : ((WORD_W+3)'(base_q[j]) + {1'b0, extent_q[j], 2'b00});
    assign in_win    = (IDX >= win_lo) && (IDX < win_end);
    assign hit_o[j]  = in_win && (addr_i >= base_q[j]) && ((WORD_W+3)'(addr_i) < top);
    assign mask_o[j] = kind_q[j] ? extent_q[j] : FULL_MASK;
  end

endmodule : paf_table

`default_nettype wire

[design/io_port_access_filter.sv]
// Top level of the I/O port access filter: channels, config registers and pipeline.
// Depends on paf_pkg, paf_stream_if and paf_table.
`default_nettype none

// Checks guest reads and writes of 32-bit device words against a table of
// permitted entries. Load items (cmd 0) write one table slot; read and write
// items are checked for alignment, then every entry in the window
// [first_entry, first_entry + entries_in_use) is compared in parallel and the
// lowest-indexed hit supplies the mask (all ones for a range entry). Each item
// gives exactly one result item. Throughput is one item per clock unless the
// output is held off. The item passes four register stages: input capture at
// the accepting edge, per-entry compare (table loads also take effect here),
// first-hit select with mask fetch, then merge into the output register.
// Each stage holds independently under back-pressure, so bubbles close up and
// a new item is taken while a finished result is still waiting. Configuration
// writes are to be made only with the pipeline empty; writes to index 3 are
// ignored. Table entries have no reset: searching a never-loaded slot gives
// undefined results.
module io_port_access_filter #(
  parameter int unsigned TABLE_DEPTH = paf_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  paf_stream_if.sink                        in_i,
  paf_stream_if.source                      out_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [1:0]                   cfg_idx_i,
  input  wire logic [paf_pkg::WORD_W-1:0]   cfg_data_i
);
  import paf_pkg::*;

  // Config registers
  logic [4:0]        entries_in_use_q;
  logic [3:0]        first_entry_q;
  logic [WORD_W-1:0] guard_base_q;

  // Stage enables
  logic en1, en2, en3, en_o;

  // Stage 1: captured input item
  logic    s1_valid_q;
  paf_in_t s1_q;

  // Stage 2: compare results
  logic                   s2_valid_q;
  logic [1:0]             s2_cmd_q;
  logic [WORD_W-1:0]      s2_port_q, s2_wval_q, s2_dval_q;
  logic                   s2_mis_q, s2_guard_q;
  logic [TABLE_DEPTH-1:0] s2_hit_q;

  // Stage 3: first hit as a one-hot vector, and its mask
  logic                   s3_valid_q;
  logic [1:0]             s3_cmd_q;
  logic [WORD_W-1:0]      s3_port_q, s3_wval_q, s3_dval_q;
  logic                   s3_mis_q, s3_guard_q, s3_found_q;
  logic [TABLE_DEPTH-1:0] s3_first_q;
  logic [WORD_W-1:0]      s3_mask_q;

  // Output register
  logic     out_valid_q;
  paf_out_t out_q, out_d;

  // Table
  paf_load_t                          load;
  logic [TABLE_DEPTH-1:0]             hit;
  logic [TABLE_DEPTH-1:0][WORD_W-1:0] eff_mask;
  logic                               s1_mis, s1_guard;
  logic [WORD_W:0]                    guard_end;
  logic [TABLE_DEPTH-1:0]             first_d;
  logic [WORD_W-1:0]                  sel_mask;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_in_use_q <= '0;
      first_entry_q    <= '0;
      guard_base_q     <= GUARD_BASE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENTRIES_IN_USE:    entries_in_use_q <= cfg_data_i[4:0];
        CFG_FIRST_ENTRY:       first_entry_q    <= cfg_data_i[3:0];
        CFG_GUARD_WINDOW_BASE: guard_base_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: each stage moves when empty or when the next one moves
  // ---------------------------------------------------------------------------
  assign en_o = !out_valid_q || out_o.ready;
  assign en3  = !s3_valid_q || en_o;
  assign en2  = !s2_valid_q || en3;
  assign en1  = !s1_valid_q || en2;

  assign in_i.ready    = en1;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // ---------------------------------------------------------------------------
  // Stage 1: capture
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en1) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_i.valid) begin
      s1_q <= in_i.payload;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 -> 2: table compare. A load writes the table as it leaves stage 1,
  // so items ahead of it have already compared and items behind see it.
  // ---------------------------------------------------------------------------
  assign load.we         = s1_valid_q && en2 && (s1_q.cmd == CMD_LOAD);
  assign load.slot       = s1_q.entry_slot;
  assign load.restricted = s1_q.entry_restricted;
  assign load.base       = s1_q.entry_address;
  assign load.extent     = s1_q.entry_extent;

  paf_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .load_i  (load),
    .count_i (entries_in_use_q),
    .first_i (first_entry_q),
    .addr_i  (s1_q.port_address),
    .hit_o   (hit),
    .mask_o  (eff_mask)
  );

  assign s1_mis    = (s1_q.port_address & ALIGN_MASK) != '0;
  assign guard_end = (WORD_W+1)'(guard_base_q) + (WORD_W+1)'(GUARD_SPAN);
  assign s1_guard  = (s1_q.port_address >= guard_base_q)
                  && ((WORD_W+1)'(s1_q.port_address) <= guard_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en2) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && s1_valid_q) begin
      s2_cmd_q   <= s1_q.cmd;
      s2_port_q  <= s1_q.port_address;
      s2_wval_q  <= s1_q.write_value;
      s2_dval_q  <= s1_q.device_value;
      s2_mis_q   <= s1_mis;
      s2_guard_q <= s1_guard;
      s2_hit_q   <= hit;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2 -> 3: isolate the lowest-index hit and fetch its mask. While an
  // item sits in stage 2 no load behind it can leave stage 1, so the table is
  // still as it was at the compare.
  // ---------------------------------------------------------------------------
  assign first_d = s2_hit_q & (~s2_hit_q + TABLE_DEPTH'(1));

  always_comb begin
    sel_mask = '0;
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      sel_mask = sel_mask | (eff_mask[j] & {WORD_W{first_d[j]}});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en3) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && s2_valid_q) begin
      s3_cmd_q   <= s2_cmd_q;
      s3_port_q  <= s2_port_q;
      s3_wval_q  <= s2_wval_q;
      s3_dval_q  <= s2_dval_q;
      s3_mis_q   <= s2_mis_q;
      s3_guard_q <= s2_guard_q;
      s3_found_q <= |s2_hit_q;
      s3_first_q <= first_d;
      s3_mask_q  <= sel_mask;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3 -> out: result build from the registered mask
  // ---------------------------------------------------------------------------
  always_comb begin
    out_d              = '0;
    out_d.status       = ST_OK;
    if (s3_cmd_q == CMD_READ || s3_cmd_q == CMD_WRITE) begin
      if (s3_mis_q) begin
        out_d.status = ST_MISALIGNED;
      end else if (!s3_found_q || s3_mask_q == '0) begin
        out_d.status = ST_DENIED;
      end else if (s3_cmd_q == CMD_READ) begin
        out_d.read_data = s3_dval_q & s3_mask_q;
      end else begin
        out_d.bus_write    = 1'b1;
        out_d.bus_address  = s3_port_q;
        out_d.write_data   = (s3_dval_q & ~s3_mask_q) | (s3_wval_q & s3_mask_q);
        out_d.guard_unlock = s3_guard_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_o) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o && s3_valid_q) begin
      out_q <= out_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_first_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> $onehot0(s3_first_q))
    else $error("first-hit vector not one-hot");

  a_found_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> (s3_found_q == (s3_first_q != '0)))
    else $error("found flag disagrees with first-hit vector");

  a_guard_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.guard_unlock |-> out_q.bus_write && (out_q.status == ST_OK))
    else $error("guard flag without an accepted write");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !en2 |=> s1_valid_q && $stable(s1_q))
    else $error("stage 1 item lost or changed while stalled");

endmodule : io_port_access_filter

`default_nettype wire

[bench/tb_io_port_access_filter.sv]
`timescale 1ns / 1ps
// Self-checking bench for io_port_access_filter: directed and random items on the
// access channel, each verdict predicted in the bench and compared field by field.
// Depends on paf_pkg, paf_stream_if and the filter RTL.

module tb_io_port_access_filter;
  import paf_pkg::*;

  localparam int unsigned DEPTH       = TABLE_DEPTH_DEF;
  localparam int unsigned LATENCY     = 4;     // capture, compare, select, merge
  localparam int unsigned STALL_LIMIT = 2000;  // cycles with no handshake at all
  localparam int unsigned LONG_HOLD   = 200;   // receiver hold-off to fill the pipe

  // cmd value outside the defined set: the filter must treat it as a no-op
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;

  paf_stream_if #(.payload_t(paf_in_t))  access_ch ();
  paf_stream_if #(.payload_t(paf_out_t)) verdict_ch ();

  io_port_access_filter dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (access_ch),
    .out_o     (verdict_ch),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Bench copy of the permission table and the partition window
  // ---------------------------------------------------------------------------
  logic        perm_kind   [DEPTH];  // 1 restricted word, 0 range of words
  logic [31:0] perm_base   [DEPTH];
  logic [31:0] perm_extent [DEPTH];  // word count or bit mask
  bit          perm_loaded [DEPTH];  // never search a slot that was not loaded

  int unsigned win_count  = 0;
  int unsigned win_first  = 0;
  logic [31:0] guard_base = GUARD_BASE_RST;

  paf_out_t pending_verdicts [$];  // verdicts still owed by the filter, oldest first
  int       n_fail      = 0;
  bit       tx_idle_en  = 1'b1;
  bit       rx_idle_en  = 1'b1;
  int       hold_req    = 0;       // one-off long hold-off for the receiver

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Verdict for one accepted item; a load also updates the bench table.
  function automatic paf_out_t filter_access(paf_in_t it);
    paf_out_t    v;
    logic [31:0] mask;
    logic [34:0] lo, hi, port_x;
    logic [32:0] guard_end;
    int unsigned i, idx;
    bit          hit;
    v      = '0;
    mask   = '0;
    hit    = 1'b0;
    port_x = {3'b000, it.port_address};
    case (it.cmd)
      CMD_LOAD: begin
        perm_kind[it.entry_slot]   = it.entry_restricted;
        perm_base[it.entry_slot]   = it.entry_address;
        perm_extent[it.entry_slot] = it.entry_extent;
        perm_loaded[it.entry_slot] = 1'b1;
      end
      CMD_READ, CMD_WRITE: begin
        if ((it.port_address & ALIGN_MASK) != '0) begin
          v.status = ST_MISALIGNED;
        end else begin
          // first hit in the window wins, even with a zero mask;
          // ends are taken without wrapping at 2^32
          for (i = 0; i < win_count; i++) begin
            idx = i + win_first;
            if (!hit && idx < DEPTH) begin
              lo = {3'b000, perm_base[idx]};
              hi = perm_kind[idx] ? lo + 35'd4 : lo + {1'b0, perm_extent[idx], 2'b00};
              if (port_x >= lo && port_x < hi) begin
                hit  = 1'b1;
                mask = perm_kind[idx] ? perm_extent[idx] : FULL_MASK;
              end
            end
          end
          if (mask == '0) begin
            v.status = ST_DENIED;
          end else if (it.cmd == CMD_READ) begin
            v.read_data = it.device_value & mask;
          end else begin
            guard_end      = {1'b0, guard_base} + {1'b0, GUARD_SPAN};
            v.bus_write    = 1'b1;
            v.bus_address  = it.port_address;
            v.write_data   = (it.device_value & ~mask) | (it.write_value & mask);
            v.guard_unlock = (it.port_address >= guard_base) &&
                             ({1'b0, it.port_address} <= guard_end);
          end
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------
  function automatic paf_in_t access_item(logic [1:0] cmd, logic [31:0] port,
                                          logic [31:0] wval, logic [31:0] dval);
    paf_in_t it;
    it              = '0;
    it.cmd          = cmd;
    it.port_address = port;
    it.write_value  = wval;
    it.device_value = dval;
    return it;
  endfunction

  function automatic paf_in_t load_item(logic [3:0] slot, logic restricted,
                                        logic [31:0] addr, logic [31:0] extent);
    paf_in_t it;
    it                  = '0;
    it.cmd              = CMD_LOAD;
    it.entry_slot       = slot;
    it.entry_restricted = restricted;
    it.entry_address    = addr;
    it.entry_extent     = extent;
    return it;
  endfunction

  function automatic paf_in_t noise_item();
    paf_in_t it;
    it.cmd              = 2'($urandom_range(0, 2));
    it.entry_slot       = 4'($urandom());
    it.entry_restricted = 1'($urandom());
    it.entry_address    = $urandom();
    it.entry_extent     = $urandom();
    it.port_address     = $urandom();
    it.write_value      = $urandom();
    it.device_value     = $urandom();
    return it;
  endfunction

  // Entry bases cluster round the guard window, the top of the map and low words,
  // so that entries overlap and accesses land on them.
  function automatic logic [31:0] hot_address();
    case ($urandom_range(0, 4))
      0:       return (guard_base + 32'($urandom_range(0, 12'hBA0))) & ~ALIGN_MASK;
      1:       return 32'hFFFF_FFFC - 32'(4 * $urandom_range(0, 8));
      2:       return 32'(4 * $urandom_range(0, 64));
      3:       return 32'h0000_1000 + 32'(4 * $urandom_range(0, 16));
      default: return $urandom();
    endcase
  endfunction

  function automatic paf_in_t random_load(logic [3:0] slot);
    paf_in_t it;
    it               = noise_item();
    it.cmd           = CMD_LOAD;
    it.entry_slot    = slot;
    it.entry_address = hot_address();
    if (it.entry_restricted) begin
      case ($urandom_range(0, 5))
        0:       it.entry_extent = '0;
        1:       it.entry_extent = FULL_MASK;
        default: it.entry_extent = $urandom();
      endcase
    end else begin
      case ($urandom_range(0, 5))
        0:       it.entry_extent = '0;
        1:       it.entry_extent = '1;
        2:       it.entry_extent = $urandom();
        default: it.entry_extent = 32'($urandom_range(1, 8));
      endcase
    end
    return it;
  endfunction

  // Mostly words covered by a window entry or on the guard window edges.
  function automatic logic [31:0] target_port();
    int unsigned k, idx, lim;
    logic [31:0] span;
    k = $urandom_range(0, 99);
    if (k < 55 && win_count != 0) begin
      idx = win_first + $urandom_range(0, win_count - 1);
      if (idx < DEPTH) begin
        if (perm_kind[idx]) return (perm_base[idx] + 32'd3) & ~ALIGN_MASK;
        span = perm_extent[idx];
        if (span == '0) return perm_base[idx];
        if ($urandom_range(0, 3) == 0) return perm_base[idx] + 32'(4 * (span - 1));
        lim = (span > 16) ? 15 : span - 1;
        return perm_base[idx] + 32'(4 * $urandom_range(0, lim));
      end
    end
    if (k < 75) begin
      case ($urandom_range(0, 5))
        0:       return (guard_base - 32'd4) & ~ALIGN_MASK;
        1:       return (guard_base + 32'd3) & ~ALIGN_MASK;
        2:       return (guard_base + 32'd4) & ~ALIGN_MASK;
        3:       return (guard_base + GUARD_SPAN - 32'd4) & ~ALIGN_MASK;
        4:       return (guard_base + GUARD_SPAN) & ~ALIGN_MASK;
        default: return (guard_base + GUARD_SPAN + 32'd4) & ~ALIGN_MASK;
      endcase
    end
    if (k < 85) return $urandom() | 32'($urandom_range(1, 3));
    return $urandom();
  endfunction

  function automatic paf_in_t random_item();
    paf_in_t     it;
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 20) return random_load(4'($urandom()));
    it              = noise_item();
    it.cmd          = (k < 60) ? CMD_READ : CMD_WRITE;
    it.port_address = target_port();
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offers one item, optionally after a short gap; valid stays high afterwards so
  // back-to-back calls keep the channel busy.
  task automatic send_item(paf_in_t it);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      access_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    access_ch.valid   <= 1'b1;
    access_ch.payload <= it;
    do @(posedge clk); while (!access_ch.ready);
    pending_verdicts.push_back(filter_access(it));
  endtask

  // Sender pauses until every owed verdict has come and the pipe is empty.
  task automatic wait_drained();
    access_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Writes all three registers back to back; only called with the pipe empty.
  task automatic set_window(int unsigned count, int unsigned first, logic [31:0] gbase);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_ENTRIES_IN_USE;
    cfg_data <= 32'(count);
    @(posedge clk);
    cfg_idx  <= CFG_FIRST_ENTRY;
    cfg_data <= 32'(first);
    @(posedge clk);
    cfg_idx  <= CFG_GUARD_WINDOW_BASE;
    cfg_data <= gbase;
    @(posedge clk);
    cfg_we     <= 1'b0;
    win_count  = count & 32'h1F;
    win_first  = first & 32'hF;
    guard_base = gbase;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: checks each verdict and paces ready
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  initial begin : verdict_sink
    paf_out_t exp_r, act_r;
    int       stall_left;
    stall_left = 0;
    verdict_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (verdict_ch.valid && verdict_ch.ready) begin
        act_r = verdict_ch.payload;
        if (pending_verdicts.size() == 0) begin
          $error("verdict item with none outstanding");
          n_fail++;
        end else begin
          exp_r = pending_verdicts.pop_front();
          check_field("status",       32'(exp_r.status),   32'(act_r.status));
          check_field("bus_write",    32'(exp_r.bus_write), 32'(act_r.bus_write));
          check_field("bus_address",  exp_r.bus_address,   act_r.bus_address);
          check_field("write_data",   exp_r.write_data,    act_r.write_data);
          check_field("read_data",    exp_r.read_data,     act_r.read_data);
          check_field("guard_unlock", 32'(exp_r.guard_unlock), 32'(act_r.guard_unlock));
        end
      end
      // one assignment to ready per edge
      if (stall_left > 0) begin
        verdict_ch.ready <= 1'b0;
        stall_left--;
      end else if (hold_req > 0) begin
        verdict_ch.ready <= 1'b0;
        stall_left = hold_req - 1;
        hold_req   = 0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        verdict_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 4) - 1;
      end else begin
        verdict_ch.ready <= 1'b1;
      end
    end
  end

  // Ends the run if neither channel moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((access_ch.valid && access_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset window is empty: aligned accesses match no entry and are denied.
  task automatic test_reset_window();
    send_item(access_item(CMD_READ,  32'h0000_1000, '0, '1));
    send_item(access_item(CMD_WRITE, 32'hFFFF_FFFC, '1, '0));
    send_item(access_item(CMD_READ,  32'h0000_0001, '0, '1));
    send_item(access_item(CMD_WRITE, 32'h0000_0002, '1, '1));
    send_item(access_item(CMD_READ,  32'hFFFF_FFFF, '1, '1));
    send_item(access_item(CMD_RESERVED, 32'h0000_1000, '1, '1));  // no-op
  endtask

  task automatic test_table_fill();
    send_item(load_item(4'd0, 1'b0, 32'h0000_1000, 32'd4));          // 0x1000..0x100C
    send_item(load_item(4'd1, 1'b1, 32'h0000_1004, 32'h0000_FF00));  // shadowed by slot 0
    send_item(load_item(4'd2, 1'b1, 32'h0000_2000, 32'h0000_0000));  // zero mask
    send_item(load_item(4'd3, 1'b1, 32'h0000_2000, 32'h0000_FFFF));  // behind the zero mask
    send_item(load_item(4'd4, 1'b1, 32'hFFFF_FFFC, 32'hA5A5_A5A5));  // top word
    send_item(load_item(4'd5, 1'b0, 32'hFFFF_FFF0, 32'hFFFF_FFFF));  // end past 2^32
    send_item(load_item(4'd6, 1'b0, GUARD_BASE_RST, 32'h0000_02E0)); // over the guard window
    send_item(load_item(4'd7, 1'b0, 32'h0000_3000, 32'd0));          // empty range
    wait_drained();
    set_window(8, 0, GUARD_BASE_RST);
  endtask

  task automatic test_access_directed();
    send_item(access_item(CMD_READ,  32'h0000_1004, '0, 32'h1234_5678)); // range beats mask
    send_item(access_item(CMD_WRITE, 32'h0000_100C, 32'hDEAD_BEEF, 32'h0F0F_0F0F));
    send_item(access_item(CMD_READ,  32'h0000_1010, '0, '1));            // one past range
    send_item(access_item(CMD_READ,  32'h0000_2000, '0, '1));            // zero mask wins
    send_item(access_item(CMD_WRITE, 32'hFFFF_FFFC, '1, '0));            // masked merge
    send_item(access_item(CMD_READ,  32'hFFFF_FFF4, '0, '1));
    send_item(access_item(CMD_WRITE, GUARD_BASE_RST, 32'h0, '1));        // guard start
    send_item(access_item(CMD_WRITE, GUARD_BASE_RST + GUARD_SPAN, '1, '0)); // guard end
    send_item(access_item(CMD_WRITE, GUARD_BASE_RST + GUARD_SPAN + 4, '1, '0));
    send_item(access_item(CMD_READ,  32'h0000_3000, '0, '1));            // count of zero
  endtask

  // Receiver holds off while the sender keeps going, so the pipe fills and
  // the access channel stalls; then the sender waits for everything to drain.
  task automatic test_backpressure();
    hold_req = LONG_HOLD;
    repeat (40) send_item(random_item());
    wait_drained();
  endtask

  task automatic test_random_phases();
    int unsigned ph, n, count, first;
    logic [31:0] gbase;
    // load every slot not yet written so any window is safe to search
    for (int s = 0; s < DEPTH; s++)
      if (!perm_loaded[s]) send_item(random_load(4'(s)));
    for (ph = 0; ph < 8; ph++) begin
      n = 150;
      case (ph)
        0: begin count = 16; first = 0;  gbase = GUARD_BASE_RST; end
        1: begin count = 0;  first = 15; gbase = '0; n = 40; end   // empty window
        2: begin count = 16; first = 15; gbase = '1; end           // window past table
        3: begin count = 1;  first = 0;  gbase = 32'hFFFF_F490; end // guard end past 2^32
        4: begin
          count = $urandom_range(0, 16);
          first = $urandom_range(0, 15);
          gbase = $urandom();
        end
        5: begin count = 16; first = 0;  gbase = '0; end
        6: begin
          count = $urandom_range(1, 16);
          first = $urandom_range(0, 15);
          gbase = $urandom() & ~ALIGN_MASK;
        end
        default: begin
          count = 8; first = 4; gbase = GUARD_BASE_RST;
          tx_idle_en = 1'b0;   // closing stretch runs flat out
          rx_idle_en = 1'b0;
        end
      endcase
      wait_drained();
      set_window(count, first, gbase);
      repeat (n) send_item(random_item());
    end
  endtask

  initial begin : main
    access_ch.valid   <= 1'b0;
    access_ch.payload <= '0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CFG_ENTRIES_IN_USE;
    cfg_data          <= '0;
    rst_n             <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_window();
    test_table_fill();
    test_access_directed();
    test_backpressure();
    test_random_phases();

    wait_drained();
    repeat (LATENCY * 4) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $error("%0d verdict items never arrived", pending_verdicts.size());
      n_fail++;
    end
    if (n_fail == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
